>>> design/bb3_pkg.sv
package bb3_pkg;

   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_MAX_HEIGHT = 1024;

   localparam int CFG_W     = 11;
   localparam int CSR_IDX_W = 2;
   localparam int CHAN_W    = 8;
   localparam int PIX_W     = 3 * CHAN_W;
   localparam int POS_W     = 10;

   localparam logic [CFG_W-1:0] RESET_WIDTH  = CFG_W'(640);
   localparam logic [CFG_W-1:0] RESET_HEIGHT = CFG_W'(480);

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = CSR_IDX_W'(1);

   // dividend 2*sum+n is at most 2*9*255+9; the quotient by 2n comes from a
   // multiply by ceil(2**RCP_SHIFT / 2n), exact for any 13-bit dividend
   localparam int SUM_W     = 12;
   localparam int DIVD_W    = 13;
   localparam int RCP_SHIFT = 18;
   localparam int RCP_W     = 18;
   localparam int PROD_W    = DIVD_W + RCP_W;

   localparam logic [RCP_W-1:0] RCP_DIV2  = RCP_W'(131072);
   localparam logic [RCP_W-1:0] RCP_DIV4  = RCP_W'(65536);
   localparam logic [RCP_W-1:0] RCP_DIV6  = RCP_W'(43691);
   localparam logic [RCP_W-1:0] RCP_DIV8  = RCP_W'(32768);
   localparam logic [RCP_W-1:0] RCP_DIV12 = RCP_W'(21846);
   localparam logic [RCP_W-1:0] RCP_DIV18 = RCP_W'(14564);

   typedef enum logic [1:0] {
      KIND_A = 2'd0,   // window centered on the previous column
      KIND_B = 2'd1,   // right edge output of a row
      KIND_D = 2'd2    // last row output during drain
   } emit_kind_type;

   typedef enum logic [1:0] {
      RD_CUR = 2'd0,
      RD_KM1 = 2'd1,
      RD_K0  = 2'd2,
      RD_KP1 = 2'd3
   } rd_sel_type;

   typedef struct packed {
      logic          accept;
      logic          rd_en;
      rd_sel_type    rd_sel;
      logic          shift_en;
      logic          wr_en;
      logic          sum_en;
      logic          div_step;
      logic          out_load;
      logic          adv_pix;
      logic          adv_drain;
      emit_kind_type kind;
   } cmd_type;

   typedef struct packed {
      logic pix_ok;
      logic drain_ok;
      logic need_a;
      logic need_b;
      logic out_free;
   } status_type;

endpackage

>>> design/bb3_ram.sv
module bb3_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> design/bb3_ctrl.sv
module bb3_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_func,
   output logic                req_ready,
   input  bb3_pkg::status_type status,
   output bb3_pkg::cmd_type    cmd
);

   typedef enum logic [9:0] {
      ST_IDLE  = 10'b00_0000_0001,
      ST_P_RD  = 10'b00_0000_0010,
      ST_P_WR  = 10'b00_0000_0100,
      ST_D_RD0 = 10'b00_0000_1000,
      ST_D_RD1 = 10'b00_0001_0000,
      ST_D_RD2 = 10'b00_0010_0000,
      ST_D_SH  = 10'b00_0100_0000,
      ST_SUM   = 10'b00_1000_0000,
      ST_DIV   = 10'b01_0000_0000,
      ST_OUT   = 10'b10_0000_0000
   } state_type;

   state_type                   state_ff, state_in;
   bb3_pkg::emit_kind_type      kind_ff, kind_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         kind_ff  <= bb3_pkg::KIND_A;
      end else begin
         state_ff <= state_in;
         kind_ff  <= kind_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      kind_in   = kind_ff;
      cmd       = '0;
      cmd.kind  = kind_ff;
      req_ready = (state_ff == ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (!req_func && status.pix_ok) begin
                  state_in = ST_P_RD;
               end else if (req_func && status.drain_ok) begin
                  state_in = ST_D_RD0;
               end
            end
         end
         ST_P_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = bb3_pkg::RD_CUR;
            state_in   = ST_P_WR;
         end
         ST_P_WR: begin
            cmd.shift_en = 1'b1;
            cmd.wr_en    = 1'b1;
            if (status.need_a) begin
               kind_in  = bb3_pkg::KIND_A;
               state_in = ST_SUM;
            end else if (status.need_b) begin
               kind_in  = bb3_pkg::KIND_B;
               state_in = ST_SUM;
            end else begin
               cmd.adv_pix = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         ST_D_RD0: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = bb3_pkg::RD_KM1;
            state_in   = ST_D_RD1;
         end
         ST_D_RD1: begin
            cmd.rd_en    = 1'b1;
            cmd.rd_sel   = bb3_pkg::RD_K0;
            cmd.shift_en = 1'b1;
            state_in     = ST_D_RD2;
         end
         ST_D_RD2: begin
            cmd.rd_en    = 1'b1;
            cmd.rd_sel   = bb3_pkg::RD_KP1;
            cmd.shift_en = 1'b1;
            state_in     = ST_D_SH;
         end
         ST_D_SH: begin
            cmd.shift_en = 1'b1;
            kind_in      = bb3_pkg::KIND_D;
            state_in     = ST_SUM;
         end
         ST_SUM: begin
            cmd.sum_en = 1'b1;
            state_in   = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            state_in     = ST_OUT;
         end
         ST_OUT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               if (kind_ff == bb3_pkg::KIND_A && status.need_b) begin
                  kind_in  = bb3_pkg::KIND_B;
                  state_in = ST_SUM;
               end else if (kind_ff == bb3_pkg::KIND_D) begin
                  cmd.adv_drain = 1'b1;
                  state_in      = ST_IDLE;
               end else begin
                  cmd.adv_pix = 1'b1;
                  state_in    = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

>>> design/bb3_dp.sv
module bb3_dp #(
   parameter int MAX_WIDTH  = bb3_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = bb3_pkg::DEF_MAX_HEIGHT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  bb3_pkg::cmd_type                cmd,
   output bb3_pkg::status_type             status,
   input  logic [bb3_pkg::CHAN_W-1:0]      req_in_red,
   input  logic [bb3_pkg::CHAN_W-1:0]      req_in_green,
   input  logic [bb3_pkg::CHAN_W-1:0]      req_in_blue,
   input  logic                            csr_we,
   input  logic [bb3_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bb3_pkg::CFG_W-1:0]       csr_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [bb3_pkg::CHAN_W-1:0]      rsp_out_red,
   output logic [bb3_pkg::CHAN_W-1:0]      rsp_out_green,
   output logic [bb3_pkg::CHAN_W-1:0]      rsp_out_blue,
   output logic [bb3_pkg::POS_W-1:0]       rsp_out_row,
   output logic [bb3_pkg::POS_W-1:0]       rsp_out_col,
   output logic                            rsp_frame_last
);

   localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int KW = $clog2(MAX_WIDTH + 1);
   localparam int RW = $clog2(MAX_HEIGHT + 1);
   localparam int CH = bb3_pkg::CHAN_W;
   localparam int PW = bb3_pkg::PIX_W;

   function automatic logic [31:0] clamp_dim(input logic [bb3_pkg::CFG_W-1:0] v,
                                             input int mx);
      logic [31:0] r;
      r = 32'(v);
      if (r == 32'd0) begin
         r = 32'd1;
      end
      if (r > 32'(mx)) begin
         r = 32'(mx);
      end
      return r;
   endfunction

   // configuration
   logic [bb3_pkg::CFG_W-1:0] fw_ff, fw_in, fh_ff, fh_in;
   logic [KW-1:0] w_eff;
   logic [RW-1:0] h_eff;
   logic          restart;

   // position counters
   logic [RW-1:0] r_ff, r_in;
   logic [AW-1:0] c_ff, c_in;
   logic [KW-1:0] k_ff, k_in;

   logic [PW-1:0] pix_ff;
   logic [PW-1:0] win_ff [3][3];
   logic [PW-1:0] older_q, newer_q;
   logic [AW-1:0] raddr;

   logic [KW-1:0] c_ext, c_next;

   always_comb begin
      fw_in   = fw_ff;
      fh_in   = fh_ff;
      restart = 1'b0;
      if (csr_we) begin
         if (csr_index == bb3_pkg::CSR_FRAME_WIDTH) begin
            fw_in   = csr_data;
            restart = 1'b1;
         end else if (csr_index == bb3_pkg::CSR_FRAME_HEIGHT) begin
            fh_in   = csr_data;
            restart = 1'b1;
         end
      end
   end

   assign w_eff  = KW'(clamp_dim(fw_ff, MAX_WIDTH));
   assign h_eff  = RW'(clamp_dim(fh_ff, MAX_HEIGHT));
   assign c_ext  = KW'(c_ff);
   assign c_next = c_ext + KW'(1);

   always_comb begin
      r_in = r_ff;
      c_in = c_ff;
      k_in = k_ff;
      if (restart) begin
         r_in = '0;
         c_in = '0;
         k_in = '0;
      end else if (cmd.adv_pix) begin
         if (c_next == w_eff) begin
            c_in = '0;
            r_in = r_ff + RW'(1);
         end else begin
            c_in = c_ff + AW'(1);
         end
      end else if (cmd.adv_drain) begin
         if (k_ff + KW'(1) == w_eff) begin
            r_in = '0;
            c_in = '0;
            k_in = '0;
         end else begin
            k_in = k_ff + KW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fw_ff <= bb3_pkg::RESET_WIDTH;
         fh_ff <= bb3_pkg::RESET_HEIGHT;
         r_ff  <= '0;
         c_ff  <= '0;
         k_ff  <= '0;
      end else begin
         fw_ff <= fw_in;
         fh_ff <= fh_in;
         r_ff  <= r_in;
         c_ff  <= c_in;
         k_ff  <= k_in;
      end
   end

   assign status.pix_ok   = (r_ff < h_eff) && (c_ext < w_eff);
   assign status.drain_ok = (r_ff >= h_eff) && (k_ff < w_eff);
   assign status.need_a   = (r_ff >= RW'(1)) && (c_ff >= AW'(1));
   assign status.need_b   = (r_ff >= RW'(1)) && (c_next == w_eff);

   always_comb begin
      case (cmd.rd_sel)
         bb3_pkg::RD_CUR: raddr = c_ff;
         bb3_pkg::RD_KM1: raddr = AW'(k_ff - KW'(1));
         bb3_pkg::RD_K0:  raddr = AW'(k_ff);
         bb3_pkg::RD_KP1: raddr = AW'(k_ff + KW'(1));
         default:         raddr = c_ff;
      endcase
   end

   bb3_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH), .AW(AW)) u_older (
      .clock (clock),
      .we    (cmd.wr_en),
      .waddr (c_ff),
      .wdata (newer_q),
      .re    (cmd.rd_en),
      .raddr (raddr),
      .rdata (older_q)
   );

   bb3_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH), .AW(AW)) u_newer (
      .clock (clock),
      .we    (cmd.wr_en),
      .waddr (c_ff),
      .wdata (pix_ff),
      .re    (cmd.rd_en),
      .raddr (raddr),
      .rdata (newer_q)
   );

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         pix_ff <= {req_in_red, req_in_green, req_in_blue};
      end
      if (cmd.shift_en) begin
         win_ff[0] <= win_ff[1];
         win_ff[1] <= win_ff[2];
         win_ff[2][0] <= older_q;
         win_ff[2][1] <= newer_q;
         win_ff[2][2] <= pix_ff;
      end
   end

   // neighbour masks per output kind
   logic [2:0] col_ok, row_ok;
   logic [1:0] ncols, nrows;
   logic [3:0] ncount;

   always_comb begin
      case (cmd.kind)
         bb3_pkg::KIND_A: begin
            col_ok = {1'b1, 1'b1, (c_ff >= AW'(2))};
            row_ok = {1'b1, 1'b1, (r_ff >= RW'(2))};
         end
         bb3_pkg::KIND_B: begin
            col_ok = {1'b1, (c_ff >= AW'(1)), 1'b0};
            row_ok = {1'b1, 1'b1, (r_ff >= RW'(2))};
         end
         bb3_pkg::KIND_D: begin
            col_ok = {(k_ff + KW'(1) < w_eff), 1'b1, (k_ff >= KW'(1))};
            row_ok = {1'b0, 1'b1, (h_eff >= RW'(2))};
         end
         default: begin
            col_ok = '0;
            row_ok = '0;
         end
      endcase
      ncols  = 2'(col_ok[0]) + 2'(col_ok[1]) + 2'(col_ok[2]);
      nrows  = 2'(row_ok[0]) + 2'(row_ok[1]) + 2'(row_ok[2]);
      ncount = 4'(ncols) * 4'(nrows);
   end

   // reciprocal of the divisor 2n for the neighbour counts that can occur
   logic [bb3_pkg::RCP_W-1:0] rcp, rcp_ff;
   logic [CH-1:0]             quo [3];

   always_comb begin
      case (ncount)
         4'd2:    rcp = bb3_pkg::RCP_DIV4;
         4'd3:    rcp = bb3_pkg::RCP_DIV6;
         4'd4:    rcp = bb3_pkg::RCP_DIV8;
         4'd6:    rcp = bb3_pkg::RCP_DIV12;
         4'd9:    rcp = bb3_pkg::RCP_DIV18;
         default: rcp = bb3_pkg::RCP_DIV2;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.sum_en) begin
         rcp_ff <= rcp;
      end
   end

   for (genvar ch = 0; ch < 3; ch++) begin : g_lane
      logic [bb3_pkg::SUM_W-1:0]  sum;
      logic [bb3_pkg::DIVD_W-1:0] x_ff;
      logic [bb3_pkg::PROD_W-1:0] prod_ff;

      always_comb begin
         sum = '0;
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               if (col_ok[i] && row_ok[j]) begin
                  sum = sum + bb3_pkg::SUM_W'(win_ff[i][j][(2-ch)*CH +: CH]);
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         if (cmd.sum_en) begin
            x_ff <= {sum, 1'b0} + bb3_pkg::DIVD_W'(ncount);
         end
         if (cmd.div_step) begin
            // quotient is the product scaled down by the reciprocal shift
            prod_ff <= bb3_pkg::PROD_W'(x_ff) * bb3_pkg::PROD_W'(rcp_ff);
         end
      end

      assign quo[ch] = prod_ff[bb3_pkg::RCP_SHIFT +: CH];
   end

   // output register
   logic                       rv_ff;
   logic [CH-1:0]              ored_ff, ogrn_ff, oblu_ff;
   logic [bb3_pkg::POS_W-1:0]  orow_ff, ocol_ff;
   logic                       olast_ff;

   assign status.out_free = !rv_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rv_ff <= 1'b1;
      end else if (rsp_ready) begin
         rv_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         ored_ff <= quo[0];
         ogrn_ff <= quo[1];
         oblu_ff <= quo[2];
         case (cmd.kind)
            bb3_pkg::KIND_A: begin
               orow_ff  <= bb3_pkg::POS_W'(r_ff - RW'(1));
               ocol_ff  <= bb3_pkg::POS_W'(c_ff - AW'(1));
               olast_ff <= 1'b0;
            end
            bb3_pkg::KIND_B: begin
               orow_ff  <= bb3_pkg::POS_W'(r_ff - RW'(1));
               ocol_ff  <= bb3_pkg::POS_W'(c_ff);
               olast_ff <= 1'b0;
            end
            default: begin
               orow_ff  <= bb3_pkg::POS_W'(h_eff - RW'(1));
               ocol_ff  <= bb3_pkg::POS_W'(k_ff);
               olast_ff <= (k_ff + KW'(1) == w_eff);
            end
         endcase
      end
   end

   assign rsp_valid      = rv_ff;
   assign rsp_out_red    = ored_ff;
   assign rsp_out_green  = ogrn_ff;
   assign rsp_out_blue   = oblu_ff;
   assign rsp_out_row    = orow_ff;
   assign rsp_out_col    = ocol_ff;
   assign rsp_frame_last = olast_ff;

endmodule

>>> design/box_blur_3x3_rgb.sv
// Channel   Direction  Handshake              Payload
// req       in         req_valid / req_ready   req_func, req_in_red/green/blue
// rsp       out        rsp_valid / rsp_ready   rsp_out_red/green/blue, rsp_out_row,
//                                              rsp_out_col, rsp_frame_last
// csr       in         csr_valid / csr_ready   csr_index, csr_data
//
// One request is processed at a time. A pixel request reads the line stores,
// then shifts the window and writes them; a drain request reads three line
// store addresses and shifts the window. Each output then takes the window
// sum, the reciprocal multiply and the output load; line store reads are one
// address per cycle. Reset is synchronous, clears the counters and sets the
// frame size to 640 x 480; the line stores are not cleared. A stalled result
// holds in the output register and the next output waits; csr_ready is always high.
module box_blur_3x3_rgb #(
   parameter int MAX_WIDTH  = bb3_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = bb3_pkg::DEF_MAX_HEIGHT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_func,
   input  logic [bb3_pkg::CHAN_W-1:0]      req_in_red,
   input  logic [bb3_pkg::CHAN_W-1:0]      req_in_green,
   input  logic [bb3_pkg::CHAN_W-1:0]      req_in_blue,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [bb3_pkg::CHAN_W-1:0]      rsp_out_red,
   output logic [bb3_pkg::CHAN_W-1:0]      rsp_out_green,
   output logic [bb3_pkg::CHAN_W-1:0]      rsp_out_blue,
   output logic [bb3_pkg::POS_W-1:0]       rsp_out_row,
   output logic [bb3_pkg::POS_W-1:0]       rsp_out_col,
   output logic                            rsp_frame_last,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [bb3_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bb3_pkg::CFG_W-1:0]       csr_data
);

   bb3_pkg::cmd_type    cmd;
   bb3_pkg::status_type status;

   // register writes never stall
   assign csr_ready = 1'b1;

   // sequence the line store access, window shift, sum, divide and output load
   bb3_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_func),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // line stores, 3x3 window, counters, divider lanes and output register
   bb3_dp #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_in_red     (req_in_red),
      .req_in_green   (req_in_green),
      .req_in_blue    (req_in_blue),
      .csr_we         (csr_valid),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_red    (rsp_out_red),
      .rsp_out_green  (rsp_out_green),
      .rsp_out_blue   (rsp_out_blue),
      .rsp_out_row    (rsp_out_row),
      .rsp_out_col    (rsp_out_col),
      .rsp_frame_last (rsp_frame_last)
   );

endmodule

>>> tb/blur_checker.sv
`timescale 1ns / 100ps

module blur_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  logic                            req_func,
   input  logic [bb3_pkg::CHAN_W-1:0]      req_in_red,
   input  logic [bb3_pkg::CHAN_W-1:0]      req_in_green,
   input  logic [bb3_pkg::CHAN_W-1:0]      req_in_blue,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  logic [bb3_pkg::CHAN_W-1:0]      rsp_out_red,
   input  logic [bb3_pkg::CHAN_W-1:0]      rsp_out_green,
   input  logic [bb3_pkg::CHAN_W-1:0]      rsp_out_blue,
   input  logic [bb3_pkg::POS_W-1:0]       rsp_out_row,
   input  logic [bb3_pkg::POS_W-1:0]       rsp_out_col,
   input  logic                            rsp_frame_last,
   input  logic                            csr_valid,
   input  logic                            csr_ready,
   input  logic [bb3_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bb3_pkg::CFG_W-1:0]       csr_data,
   output int                              fail_count,
   output int                              pending
);
   import bb3_pkg::*;

   localparam int MAXW = DEF_MAX_WIDTH;
   localparam int MAXH = DEF_MAX_HEIGHT;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic [POS_W-1:0]  row;
      logic [POS_W-1:0]  col;
      logic              last;
   } blur_px_t;

   blur_px_t          blurred_q[$];
   logic [CFG_W-1:0]  width_reg, height_reg;
   logic [PIX_W-1:0]  upper_line[MAXW];
   logic [PIX_W-1:0]  lower_line[MAXW];
   logic [PIX_W-1:0]  win[3][3];   // [column][row]
   int                row_at, col_at, drain_at;

   assign pending = blurred_q.size();

   function automatic int clamp_dim(logic [CFG_W-1:0] v, int max_v);
      int d;
      d = v;
      if (d < 1) d = 1;
      if (d > max_v) d = max_v;
      return d;
   endfunction

   function automatic logic [CHAN_W-1:0] round_mean(int sum, int n);
      return CHAN_W'((2 * sum + n) / (2 * n));
   endfunction

   // average the pixels whose column and row both lie in the frame
   task automatic push_mean(input logic [PIX_W-1:0] nbr[3][3], input bit cok[3],
                            input bit rok[3], input int row, input int col,
                            input bit last);
      int sr, sg, sb, n;
      blur_px_t px;
      sr = 0; sg = 0; sb = 0; n = 0;
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++)
            if (cok[i] && rok[j]) begin
               sr += nbr[i][j][23:16];
               sg += nbr[i][j][15:8];
               sb += nbr[i][j][7:0];
               n++;
            end
      if (n == 0) n = 1;
      px.red   = round_mean(sr, n);
      px.green = round_mean(sg, n);
      px.blue  = round_mean(sb, n);
      px.row   = POS_W'(row);
      px.col   = POS_W'(col);
      px.last  = last;
      blurred_q.push_back(px);
   endtask

   task automatic restart_frame();
      row_at = 0; col_at = 0; drain_at = 0;
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++)
            win[i][j] = '0;
   endtask

   task automatic predict_request();
      int w, h, r, c, k;
      logic [PIX_W-1:0] nbr[3][3];
      bit cok[3], rok[3];
      w = clamp_dim(width_reg, MAXW);
      h = clamp_dim(height_reg, MAXH);
      if (req_func) begin
         k = drain_at;
         if (row_at < h || k >= w) return;
         for (int d = 0; d < 3; d++) begin
            cok[d] = (k + d >= 1) && (k + d - 1 < w);
            nbr[d][0] = cok[d] ? upper_line[k + d - 1] : '0;
            nbr[d][1] = cok[d] ? lower_line[k + d - 1] : '0;
            nbr[d][2] = '0;
         end
         rok[0] = (h >= 2); rok[1] = 1; rok[2] = 0;
         push_mean(nbr, cok, rok, h - 1, k, k + 1 == w);
         drain_at = k + 1;
         if (k + 1 == w) restart_frame();
      end else begin
         r = row_at;
         c = col_at;
         if (r >= h || c >= w) return;
         win[0] = win[1];
         win[1] = win[2];
         win[2][0] = upper_line[c];
         win[2][1] = lower_line[c];
         win[2][2] = {req_in_red, req_in_green, req_in_blue};
         upper_line[c] = lower_line[c];
         lower_line[c] = {req_in_red, req_in_green, req_in_blue};
         if (r >= 1) begin
            rok[0] = (r >= 2); rok[1] = 1; rok[2] = 1;
            if (c >= 1) begin
               cok[0] = (c >= 2); cok[1] = 1; cok[2] = 1;
               push_mean(win, cok, rok, r - 1, c - 1, 0);
            end
            if (c + 1 == w) begin
               nbr[0] = win[1];
               nbr[1] = win[2];
               for (int j = 0; j < 3; j++) nbr[2][j] = '0;
               cok[0] = (c >= 1); cok[1] = 1; cok[2] = 0;
               push_mean(nbr, cok, rok, r - 1, c, 0);
            end
         end
         if (c + 1 == w) begin
            col_at = 0;
            row_at = r + 1;
         end else begin
            col_at = c + 1;
         end
      end
   endtask

   task automatic check_result();
      blur_px_t got, exp_px;
      got = '{rsp_out_red, rsp_out_green, rsp_out_blue, rsp_out_row, rsp_out_col,
              rsp_frame_last};
      if (blurred_q.size() == 0) begin
         fail_count++;
         if (fail_count <= 10)
            $display("unexpected result: r=%0d c=%0d rgb=%h %h %h last=%0d",
                     got.row, got.col, got.red, got.green, got.blue, got.last);
         return;
      end
      exp_px = blurred_q.pop_front();
      if (got !== exp_px) begin
         fail_count++;
         if (fail_count <= 10)
            $display({"mismatch: expected r=%0d c=%0d rgb=%h %h %h last=%0d,",
                      " got r=%0d c=%0d rgb=%h %h %h last=%0d"},
                     exp_px.row, exp_px.col, exp_px.red, exp_px.green, exp_px.blue,
                     exp_px.last, got.row, got.col, got.red, got.green, got.blue,
                     got.last);
      end
   endtask

   initial begin
      fail_count = 0;
      width_reg  = RESET_WIDTH;
      height_reg = RESET_HEIGHT;
      for (int i = 0; i < MAXW; i++) begin
         upper_line[i] = '0;
         lower_line[i] = '0;
      end
      restart_frame();
   end

   always @(posedge clock) begin
      if (reset) begin
         width_reg  = RESET_WIDTH;
         height_reg = RESET_HEIGHT;
         restart_frame();
      end else begin
         if (rsp_valid && rsp_ready) check_result();
         if (req_valid && req_ready) predict_request();
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_FRAME_WIDTH) begin
               width_reg = csr_data;
               restart_frame();
            end else if (csr_index == CSR_FRAME_HEIGHT) begin
               height_reg = csr_data;
               restart_frame();
            end
         end
      end
   end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import bb3_pkg::*;

   localparam logic FUNC_PIXEL = 1'b0;
   localparam logic FUNC_DRAIN = 1'b1;
   localparam int   QUIET_CYCLES = 64;   // a no-result request finishes well inside this

   logic                   clock, reset;
   logic                   req_valid, req_ready, req_func;
   logic [CHAN_W-1:0]      req_in_red, req_in_green, req_in_blue;
   logic                   rsp_valid, rsp_ready;
   logic [CHAN_W-1:0]      rsp_out_red, rsp_out_green, rsp_out_blue;
   logic [POS_W-1:0]       rsp_out_row, rsp_out_col;
   logic                   rsp_frame_last;
   logic                   csr_valid, csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index;
   logic [CFG_W-1:0]       csr_data;
   int                     fail_count, pending;
   int                     send_idle_pct, recv_stall_pct;
   int                     items_sent;

   box_blur_3x3_rgb dut (.*);

   blur_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // random backpressure on the result side; the rate follows the current phase
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   task automatic set_phase();
      if (items_sent < 700) begin
         send_idle_pct = 19; recv_stall_pct = 54;
      end else if (items_sent < 1400) begin
         send_idle_pct = 54; recv_stall_pct = 19;
      end else begin
         send_idle_pct = 0; recv_stall_pct = 0;
      end
   endtask

   // hold valid and payload until the request is taken
   task automatic send_request(input logic func, input logic [PIX_W-1:0] rgb);
      set_phase();
      if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_func     <= func;
      req_in_red   <= rgb[23:16];
      req_in_green <= rgb[15:8];
      req_in_blue  <= rgb[7:0];
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
   endtask

   // drop valid, let every expected result arrive, then let trailing work settle
   task automatic wait_quiet();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_frame(input logic [CFG_W-1:0] w_val, input logic [CFG_W-1:0] h_val);
      wait_quiet();
      write_csr(CSR_FRAME_WIDTH, w_val);
      write_csr(CSR_FRAME_HEIGHT, h_val);
   endtask

   function automatic logic [PIX_W-1:0] rand_pixel();
      logic [PIX_W-1:0] p;
      p = PIX_W'($urandom);
      // bias some channels to the extremes
      for (int i = 0; i < 3; i++)
         case ($urandom_range(9))
            0: p[i*8 +: 8] = 8'h00;
            1: p[i*8 +: 8] = 8'hff;
            default: ;
         endcase
      return p;
   endfunction

   // stream one frame; cut > 0 stops early, leaving a broken frame
   task automatic run_frame(input int w, input int h, input int cut);
      int total;
      total = w * h;
      for (int i = 0; i < total; i++) begin
         if (cut > 0 && i == cut) return;
         // drain too early: must give nothing
         if ($urandom_range(99) < 3) send_request(FUNC_DRAIN, PIX_W'($urandom));
         send_request(FUNC_PIXEL, rand_pixel());
      end
      // pixels past the frame are ignored
      if ($urandom_range(99) < 30)
         repeat ($urandom_range(1, 2)) send_request(FUNC_PIXEL, rand_pixel());
      for (int i = 0; i < w; i++) send_request(FUNC_DRAIN, PIX_W'($urandom));
   endtask

   initial begin
      #20_000_000;
      $display("** box_blur_3x3_rgb: FAILED **");
      $finish;
   end

   initial begin
      int w, h, sel;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_func       = FUNC_PIXEL;
      req_in_red     = '0;
      req_in_green   = '0;
      req_in_blue    = '0;
      rsp_ready      = 1'b0;
      csr_valid      = 1'b0;
      csr_index      = CSR_FRAME_WIDTH;
      csr_data       = '0;
      send_idle_pct  = 19;
      recv_stall_pct = 54;
      items_sent     = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: 3x3 frame with extreme colors, early drain, extra pixel
      set_frame(CFG_W'(3), CFG_W'(3));
      send_request(FUNC_DRAIN, '0);
      for (int i = 0; i < 9; i++)
         send_request(FUNC_PIXEL, (i % 2) ? 24'hffffff : 24'h000000);
      send_request(FUNC_PIXEL, 24'h123456);
      repeat (3) send_request(FUNC_DRAIN, 24'hffffff);
      // directed: width written as zero runs as one, single-pixel frame
      set_frame(CFG_W'(0), CFG_W'(1));
      send_request(FUNC_PIXEL, 24'hff00ff);
      send_request(FUNC_DRAIN, '0);
      // ignored register indexes leave the frame size alone
      wait_quiet();
      write_csr(CSR_IDX_W'(2), CFG_W'(5));
      write_csr(CSR_IDX_W'(3), CFG_W'(7));
      send_request(FUNC_PIXEL, 24'h00ff00);
      send_request(FUNC_DRAIN, '0);

      // random frames
      while (items_sent < 2000) begin
         sel = $urandom_range(99);
         if (sel < 3 && items_sent < 900) begin
            // oversized height clamps to the maximum, one column wide
            set_frame(CFG_W'(1), CFG_W'(2047));
            run_frame(1, DEF_MAX_HEIGHT, 0);
         end else if (sel < 6 && items_sent < 900) begin
            // oversized width clamps to the maximum; stop early in the second row
            set_frame(CFG_W'(2047), CFG_W'(2));
            run_frame(DEF_MAX_WIDTH, 2, DEF_MAX_WIDTH + 8);
         end else begin
            w = ($urandom_range(9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            h = $urandom_range(1, 6);
            set_frame(CFG_W'(w), CFG_W'(h));
            // a few frames are cut short and restarted by the next write
            run_frame(w, h, ($urandom_range(99) < 8) ? $urandom_range(1, w * h) : 0);
            // sometimes run a second frame back to back without a write
            if ($urandom_range(99) < 25) run_frame(w, h, 0);
         end
         // hold off until all results are in
         if ($urandom_range(99) < 10) wait_quiet();
      end

      wait_quiet();
      if (fail_count == 0 && pending == 0) begin
         $display("** box_blur_3x3_rgb: PASSED **");
      end else begin
         $display("** box_blur_3x3_rgb: FAILED **");
      end
      $finish;
   end

endmodule

>>> filelist.f
design/bb3_pkg.sv
design/bb3_ram.sv
design/bb3_ctrl.sv
design/bb3_dp.sv
design/box_blur_3x3_rgb.sv
tb/blur_checker.sv
tb/tb_top.sv
